// File: design/srie_pkg.sv
// ----------------------------------------------------------------------------
// srie_pkg: shared types and constants of the small RISC instruction executor
// Opcode codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package srie_pkg;

    localparam int unsigned WORD_BITS = 32;

    typedef enum logic [4:0] {
        OP_HALT  = 5'd0,
        OP_ADD   = 5'd1,
        OP_SUB   = 5'd2,
        OP_MUL   = 5'd3,
        OP_DIV   = 5'd4,
        OP_AND   = 5'd5,
        OP_OR    = 5'd6,
        OP_XOR   = 5'd7,
        OP_SHL   = 5'd8,
        OP_SHR   = 5'd9,
        OP_SLT   = 5'd10,
        OP_SLE   = 5'd11,
        OP_SEQ   = 5'd12,
        OP_LOAD  = 5'd13,
        OP_STORE = 5'd14,
        OP_JUMP  = 5'd15,
        OP_BRAZ  = 5'd16,
        OP_BRANZ = 5'd17
    } opcode_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ_A,
        ST_READ_B,
        ST_EXEC,
        ST_DIV,
        ST_MEM,
        ST_LOAD,
        ST_JUMP_RD,
        ST_JUMP_TGT,
        ST_WRITE,
        ST_OUT
    } state_t;

endpackage

// File: design/small_risc_instruction_executor_unit.sv
// ----------------------------------------------------------------------------
// small_risc_instruction_executor_unit: executes one instruction per transfer
// A sequencer drives one ALU over register file and data memory ports.
// ----------------------------------------------------------------------------
// Usage: the slave stream (s_tvalid, s_tready, s_tdata) carries one 32-bit
// instruction word per transfer. The master stream (m_tvalid, m_tready,
// m_tdata) returns one result per instruction with next pc, register write,
// memory access, halt flag and running cycle total.
// The result is loaded into the output register in ST_OUT. ALU operations
// pass ST_READ_A, ST_READ_B, ST_EXEC and ST_WRITE first; multiply and divide
// add ST_DIV, loads add ST_LOAD, stores add ST_MEM, a jump through a register
// passes ST_READ_A, ST_JUMP_RD and ST_JUMP_TGT, and branches, direct jumps,
// halt, ignored and unknown words go to ST_OUT early. A divide iterates one
// quotient bit per cycle in ST_DIV. The sequencer is ready again in the cycle
// after it loads the output register, so it takes no new instruction before then.
// After reset the block runs a clearing pass over DATA_WORDS addresses that
// writes the reset values into the register file and the data memory before
// s_tready rises. While the receiver stalls, the block accepts one more
// instruction and holds it at its last step until the output register is
// free; s_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module small_risc_instruction_executor_unit #(
    parameter int unsigned DATA_WORDS = 1024,
    parameter int unsigned PC_BITS    = 22
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // instruction[31:0]
    input  logic [31:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_pc[21:0], reg_write[22], reg_index[27:23], reg_value[59:28],
    // mem_write[60], mem_address[70:61], stored_value[102:71], halted[103],
    // cycle_total[135:104], zero fill[143:136]
    output logic [143:0] m_tdata
);
    import srie_pkg::*;

    localparam int unsigned AW = $clog2(DATA_WORDS);
    localparam logic [31:0] PC_MASK = 32'((64'd1 << PC_BITS) - 64'd1);
    localparam int unsigned CW = (AW > 5) ? AW : 5;

    logic [31:0] regs [32];
    logic [31:0] dmem [DATA_WORDS];

    state_t      state_reg, state_next;
    logic [31:0] instr_reg, instr_next;
    logic [31:0] a_reg, a_next, b_reg, b_next, res_reg, res_next;
    logic [31:0] pc_reg, pc_next, npc_reg, npc_next, cyc_reg, cyc_next;
    logic        halt_reg, halt_next;
    logic [CW:0] cnt_reg, cnt_next;
    logic [31:0] rq_reg, rq_next, rr_reg, rr_next;
    logic        rw_reg, rw_next, mw_reg, mw_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [31:0] rdata_reg, mdata_reg;
    logic [4:0]  raddr;
    logic        rf_we;
    logic [4:0]  rf_wa;
    logic [31:0] rf_wd;
    logic        dm_we;
    logic [AW-1:0] dm_wa;
    logic [31:0] dm_wd;
    logic [143:0] out_reg, out_next;
    logic        mv_reg, mv_next;

    logic [4:0] op, ra, rd;
    logic [31:0] add_s, sub_s, mul_p, b_op, div_a, div_b, trial;
    logic [32:0] rem_sh;
    logic        div_neg, rem_neg;

    assign op = instr_reg[31:27];
    assign ra = instr_reg[26:22];
    assign rd = instr_reg[4:0];
    assign b_op = instr_reg[21] ? {16'd0, instr_reg[20:5]} :
                  ((state_reg == ST_EXEC && op != OP_STORE) ? rdata_reg : b_reg);
    assign add_s = a_reg + b_op;
    assign sub_s = a_reg - b_op;
    assign mul_p = a_reg * b_op;
    assign div_a = a_reg[31] ? -a_reg : a_reg;
    assign div_b = b_op[31] ? -b_op : b_op;
    assign rem_sh = {rr_reg, rq_reg[31]};
    assign trial = 32'(rem_sh - {1'b0, div_b});
    assign div_neg = a_reg[31] ^ b_op[31];
    assign rem_neg = rem_sh < {1'b0, div_b};

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            regs[rf_wa] <= rf_wd;
        end
        rdata_reg <= regs[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dmem[dm_wa] <= dm_wd;
        end
        mdata_reg <= dmem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            pc_reg    <= '0;
            cyc_reg   <= '0;
            halt_reg  <= 1'b0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            cyc_reg   <= cyc_next;
            halt_reg  <= halt_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        instr_reg <= instr_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        res_reg   <= res_next;
        npc_reg   <= npc_next;
        rq_reg    <= rq_next;
        rr_reg    <= rr_next;
        rw_reg    <= rw_next;
        mw_reg    <= mw_next;
        addr_reg  <= addr_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        state_next = state_reg;
        instr_next = instr_reg;
        a_next = a_reg;
        b_next = b_reg;
        res_next = res_reg;
        pc_next = pc_reg;
        npc_next = npc_reg;
        cyc_next = cyc_reg;
        halt_next = halt_reg;
        cnt_next = cnt_reg;
        rq_next = rq_reg;
        rr_next = rr_reg;
        rw_next = rw_reg;
        mw_next = mw_reg;
        addr_next = addr_reg;
        out_next = out_reg;
        mv_next = mv_reg;
        raddr = ra;
        rf_we = 1'b0;
        rf_wa = rd;
        rf_wd = res_reg;
        dm_we = 1'b0;
        dm_wa = addr_reg;
        dm_wd = rdata_reg;
        s_tready = 1'b0;
        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            ST_INIT:
            begin
                dm_we = 1'b1;
                dm_wa = cnt_reg[AW-1:0];
                dm_wd = 32'(cnt_reg);
                rf_we = (cnt_reg < 32);
                rf_wa = cnt_reg[4:0];
                rf_wd = 32'(cnt_reg);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (CW+1)'(DATA_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    instr_next = s_tdata;
                    rw_next = 1'b0;
                    mw_next = 1'b0;
                    res_next = '0;
                    addr_next = '0;
                    npc_next = (pc_reg + 32'd1) & PC_MASK;
                    state_next = ST_READ_A;
                end
            end
            ST_READ_A:
            begin
                raddr = ra;
                state_next = ST_READ_B;
                if (halt_reg)
                begin
                    npc_next = pc_reg;
                    state_next = ST_OUT;
                end
                else if (op == OP_HALT)
                begin
                    halt_next = 1'b1;
                    state_next = ST_OUT;
                end
                else if (op == OP_JUMP)
                begin
                    rw_next = 1'b1;
                    res_next = npc_reg;
                    state_next = ST_JUMP_RD;
                end
                else if (op > OP_BRANZ)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_READ_B:
            begin
                a_next = rdata_reg;
                raddr = (op == OP_STORE) ? rd : instr_reg[9:5];
                state_next = ST_EXEC;
                if (op == OP_BRAZ || op == OP_BRANZ)
                begin
                    if ((op == OP_BRAZ) == (rdata_reg == 32'd0))
                    begin
                        npc_next = {10'd0, instr_reg[21:0]} & PC_MASK;
                    end
                    state_next = ST_OUT;
                end
                else if (op == OP_STORE)
                begin
                    raddr = instr_reg[9:5];
                    state_next = ST_MEM;
                end
            end
            ST_MEM:
            begin
                b_next = rdata_reg;
                raddr = rd;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (op != OP_STORE)
                begin
                    b_next = rdata_reg;
                end
                state_next = ST_WRITE;
                rw_next = 1'b1;
                cyc_next = cyc_reg + 32'd1;
                unique case (op)
                    OP_ADD: res_next = add_s;
                    OP_SUB: res_next = sub_s;
                    OP_MUL:
                    begin
                        state_next = ST_DIV;
                        cnt_next = '1;
                        cyc_next = cyc_reg + 32'd2;
                    end
                    OP_DIV:
                    begin
                        cyc_next = cyc_reg + 32'd2;
                        rq_next = div_a;
                        rr_next = '0;
                        cnt_next = '0;
                        state_next = ST_DIV;
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
                if (op == OP_AND) res_next = a_reg & b_op;
                if (op == OP_OR)  res_next = a_reg | b_op;
                if (op == OP_XOR) res_next = a_reg ^ b_op;
                if (op == OP_SHL) res_next = (b_op >= 32) ? '0 : (a_reg << b_op[4:0]);
                if (op == OP_SHR) res_next = (b_op >= 32) ? {32{a_reg[31]}} :
                                    32'($signed(a_reg) >>> b_op[4:0]);
                if (op == OP_SLT) res_next = {31'd0, $signed(a_reg) < $signed(b_op)};
                if (op == OP_SLE) res_next = {31'd0, $signed(a_reg) <= $signed(b_op)};
                if (op == OP_SEQ) res_next = {31'd0, a_reg == b_op};
                if (op == OP_LOAD || op == OP_STORE)
                begin
                    cyc_next = cyc_reg + 32'd100;
                    addr_next = AW'(add_s % DATA_WORDS);
                    rw_next = (op == OP_LOAD);
                    mw_next = (op == OP_STORE);
                    res_next = (op == OP_STORE) ? rdata_reg : '0;
                    state_next = (op == OP_STORE) ? ST_WRITE : ST_LOAD;
                end
            end
            ST_DIV:
            begin
                if (op == OP_MUL)
                begin
                    res_next = mul_p;
                    state_next = ST_WRITE;
                end
                else if (cnt_reg == (CW+1)'(32))
                begin
                    if (b_op == 32'd0)
                    begin
                        res_next = '1;
                    end
                    else
                    begin
                        res_next = div_neg ? -rq_reg : rq_reg;
                    end
                    state_next = ST_WRITE;
                end
                else
                begin
                    rr_next = rem_neg ? rem_sh[31:0] : trial;
                    rq_next = {rq_reg[30:0], !rem_neg};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_WRITE;
            end
            ST_JUMP_RD:
            begin
                rf_we = 1'b1;
                rf_wd = npc_reg;
                raddr = instr_reg[9:5];
                state_next = ST_JUMP_TGT;
                if (instr_reg[26])
                begin
                    npc_next = {11'd0, instr_reg[25:5]} & PC_MASK;
                    state_next = ST_OUT;
                end
            end
            ST_JUMP_TGT:
            begin
                raddr = instr_reg[9:5];
                state_next = ST_OUT;
            end
            ST_WRITE:
            begin
                if (op == OP_LOAD)
                begin
                    res_next = mdata_reg;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                raddr = instr_reg[9:5];
                if (!mv_reg || m_tready)
                begin
                    if (op == OP_JUMP && !halt_reg && !instr_reg[26])
                    begin
                        npc_next = rdata_reg & PC_MASK;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (state_reg == ST_OUT && (!mv_reg || m_tready))
        begin
            if (op == OP_STORE && mw_reg)
            begin
                dm_we = 1'b1;
                dm_wa = addr_reg;
                dm_wd = res_reg;
            end
            else if (rw_reg && op != OP_JUMP)
            begin
                rf_we = 1'b1;
                rf_wa = rd;
                rf_wd = res_reg;
            end
            if (op == OP_JUMP && !halt_reg && !instr_reg[26])
            begin
                pc_next = rdata_reg & PC_MASK;
            end
            else
            begin
                pc_next = npc_reg;
            end
            out_next = '0;
            out_next[21:0] = (op == OP_JUMP && !halt_reg && !instr_reg[26]) ?
                             rdata_reg[21:0] & PC_MASK[21:0] : npc_reg[21:0];
            out_next[22] = rw_reg;
            out_next[27:23] = rw_reg ? rd : 5'd0;
            out_next[59:28] = rw_reg ? res_reg : 32'd0;
            out_next[60] = mw_reg;
            out_next[70:61] = 10'(addr_reg);
            out_next[102:71] = mw_reg ? res_reg : 32'd0;
            out_next[103] = halt_reg;
            out_next[135:104] = cyc_reg;
            mv_next = 1'b1;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[60]) |-> !m_tdata[22])
        else $error("store reported register write");
    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(halt_reg))
        else $error("halt flag cleared");

endmodule
